/* rtl/bcc_pkg.sv */
// Shared types and constants for the bipartite crossing counter.
package bcc_pkg;

  localparam int ROW_W       = 32;
  localparam int CFG_W       = 6;
  localparam int TOTAL_W     = 18;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_W-1:0] NUM_COLUMNS_RST = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } bcc_state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic out_load;
  } bcc_cmd_t;

  typedef struct packed {
    logic rows_full;
    logic col_zero;
    logic last;
    logic out_free;
  } bcc_status_t;

endpackage

/* rtl/bcc_ctrl.sv */
// Controller for the crossing counter: accept, column walk, result hand-off.
module bcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tlast,
  output logic                 s_axis_tready,
  input  bcc_pkg::bcc_status_t status_i,
  output bcc_pkg::bcc_cmd_t    cmd_o
);

  bcc_pkg::bcc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      bcc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (!status_i.rows_full) begin
            state_d = bcc_pkg::ST_SCAN;
          end else if (s_axis_tlast) begin
            state_d = bcc_pkg::ST_FINISH;
          end
        end
      end
      bcc_pkg::ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (status_i.col_zero) begin
          state_d = status_i.last ? bcc_pkg::ST_FINISH : bcc_pkg::ST_IDLE;
        end
      end
      bcc_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bcc_datapath.sv */
// Datapath: column counts, suffix accumulator, running total and result register.
module bcc_datapath #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bcc_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [bcc_pkg::ROW_W-1:0]         s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,
  input  bcc_pkg::bcc_cmd_t                 cmd_i,
  output bcc_pkg::bcc_status_t              status_o
);

  localparam int NCOL  = (MAX_COLS < bcc_pkg::ROW_W) ? MAX_COLS : bcc_pkg::ROW_W;
  localparam int CW    = $clog2(NCOL);
  localparam int NW    = $clog2(NCOL + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int SW    = $clog2(NCOL * MAX_ROWS + 1);
  localparam int TW    = bcc_pkg::TOTAL_W;
  localparam int PAD_W = bcc_pkg::OUT_TDATA_W - TW;

  logic [bcc_pkg::CFG_W-1:0] num_columns_q;
  logic [NCOL-1:0]           row_q;
  logic                      last_q;
  logic [CW-1:0]             col_q;
  logic [SW-1:0]             suffix_q;
  logic [TW-1:0]             total_q, total_d;
  logic [RW-1:0]             rows_seen_q;
  logic                      overflow_q;
  logic [RW-1:0]             counts_q [NCOL];
  logic                      out_valid_q;
  logic [TW-1:0]             out_count_q;
  logic                      out_ovf_q;

  logic [NW-1:0]   active_cols;
  logic [NCOL-1:0] row_masked;
  logic [CW-1:0]   start_col;
  logic [TW:0]     sum;
  logic            col_zero;
  logic            rows_full;

  always_comb begin
    if ({1'b0, num_columns_q} > 7'(NCOL)) begin
      active_cols = NW'(NCOL);
    end else begin
      active_cols = NW'(num_columns_q);
    end
    for (int i = 0; i < NCOL; i++) begin
      row_masked[i] = s_axis_tdata[i] & (NW'(i) < active_cols);
    end
    start_col = (active_cols == '0) ? '0 : CW'(active_cols - NW'(1));
  end

  assign sum       = {1'b0, total_q} + (TW + 1)'(suffix_q);
  assign total_d   = !row_q[col_q] ? total_q : (sum[TW] ? '1 : sum[TW-1:0]);
  assign col_zero  = (col_q == '0);
  assign rows_full = (rows_seen_q == RW'(MAX_ROWS));

  assign status_o.rows_full = rows_full;
  assign status_o.col_zero  = col_zero;
  assign status_o.last      = last_q;
  assign status_o.out_free  = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_columns_q <= bcc_pkg::NUM_COLUMNS_RST;
    end else if (cfg_valid_i) begin
      num_columns_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q    <= row_masked;
      last_q   <= s_axis_tlast;
      col_q    <= start_col;
      suffix_q <= '0;
    end else if (cmd_i.step) begin
      col_q    <= col_q - CW'(1);
      suffix_q <= suffix_q + SW'(counts_q[col_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      rows_seen_q <= '0;
      overflow_q  <= 1'b0;
      for (int i = 0; i < NCOL; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.out_load) begin
      total_q     <= '0;
      rows_seen_q <= '0;
      overflow_q  <= 1'b0;
      for (int i = 0; i < NCOL; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accept && rows_full) begin
        overflow_q <= 1'b1;
      end
      if (cmd_i.step) begin
        total_q <= total_d;
        if (col_zero) begin
          rows_seen_q <= rows_seen_q + RW'(1);
          for (int i = 0; i < NCOL; i++) begin
            counts_q[i] <= counts_q[i] + RW'(row_q[i]);
          end
        end
      end
    end
  end

  // result register, frees the scan side while a beat waits downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= total_q;
      out_ovf_q   <= overflow_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PAD_W'(0), out_count_q};
  assign m_axis_tuser  = out_ovf_q;

`ifndef SYNTHESIS
  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q <= RW'(MAX_ROWS))
    else $error("rows_seen above limit");

  a_clear_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (total_q == '0 && rows_seen_q == '0 && !overflow_q))
    else $error("matrix state not cleared after result");

  a_row_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && col_zero && !cmd_i.out_load)
      |=> rows_seen_q == $past(rows_seen_q) + RW'(1))
    else $error("finished row not counted");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && out_valid_q) |-> m_axis_tready)
    else $error("result overwritten before taken");
`endif

endmodule

/* rtl/bipartite_crossing_counter.sv */
// Top level of the two-layer edge crossing counter.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata[31:0] row_bits, tlast last_row
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata[17:0] crossing_count, tuser row_overflow
//  cfg       in   cfg_valid_i / cfg_ready_o        cfg_data_i num_columns
//
// A row takes an accept state (ST_IDLE) followed by the column walk (ST_SCAN), which
// steps the suffix accumulator one column per cycle, from the highest active column down to 0.
// A row past the row limit is accepted without a walk. After the last row, ST_FINISH loads the result.
// Reset clears counts, total and the result valid flag; num_columns resets to 32.
// A pending result beat does not stall rows; only loading the next result waits for it.
module bipartite_crossing_counter #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bcc_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bcc_pkg::ROW_W-1:0]       s_axis_tdata,  // [31:0] row_bits
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [17:0] crossing_count, rest zero
  output logic                            m_axis_tuser,  // [0] row_overflow
  output logic                            m_axis_tlast
);

  bcc_pkg::bcc_cmd_t    cmd;
  bcc_pkg::bcc_status_t status;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tlast = 1'b1;

  bcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  bcc_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
